// ----- hw/rtl/ogcu_pkg.sv -----
// Shared types, constants and helpers of the occupancy grid cell updater.
package ogcu_pkg;

    // Map size defaults
    localparam int MAP_WIDTH_DEF  = 64;
    localparam int MAP_HEIGHT_DEF = 64;

    // Datapath widths
    localparam int DW = 24;   // signed cell offset dx, dy
    localparam int QW = 45;   // one squared offset
    localparam int SW = 46;   // squared distance
    localparam int CW = 36;   // CORDIC x, y
    localparam int CORDIC_STEPS = 15;
    localparam int Q_DEPTH = 4;

    localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };

    localparam logic [15:0] HALF_TURN  = 16'd32768;
    localparam logic [15:0] BEAM_STEP  = 16'd8192;
    localparam logic [15:0] BEAM_FIRST = 16'hC000;   // minus a quarter turn

    // Log-odds limits and steps
    localparam logic signed [8:0] LO_MAX  = 9'sd100;
    localparam logic signed [8:0] LO_MIN  = -9'sd100;
    localparam logic signed [8:0] L_OCC   = 9'sd2;
    localparam logic signed [8:0] L_FREE  = -9'sd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd0;
    localparam logic [1:0] VERDICT_OCC     = 2'd1;
    localparam logic [1:0] VERDICT_FREE    = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_MAX_REACH     = 3'd0;
    localparam logic [2:0] CFG_FIELD_HALF    = 3'd1;
    localparam logic [2:0] CFG_BEAM_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_HIT_TOL       = 3'd3;
    localparam logic [2:0] CFG_CELL_PITCH    = 3'd4;
    localparam logic [2:0] CFG_CENTER_OFFSET = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_MAX_REACH     = 16'd1600;
    localparam logic [15:0] RST_FIELD_HALF    = 16'd24576;
    localparam logic [15:0] RST_BEAM_WIDTH    = 16'd4915;
    localparam logic [15:0] RST_HIT_TOL       = 16'd32;
    localparam logic [15:0] RST_CELL_PITCH    = 16'd16;
    localparam logic [15:0] RST_CENTER_OFFSET = 16'd8;

    typedef struct packed {
        logic [15:0] max_reach;
        logic [15:0] field_half;
        logic [15:0] beam_width;
        logic [15:0] hit_tol;
        logic [15:0] cell_pitch;
        logic [15:0] center_offset;
    } t_cfg;

    // Item context carried along the geometry pipeline
    typedef struct packed {
        logic [15:0]       head;
        logic [4:0][15:0]  rng;
        logic              in_map;
        logic              zero;
        logic [QW-1:0]     sqx;
        logic [QW-1:0]     sqy;
        logic [SW-1:0]     s;
        logic [31:0]       rm2;
    } t_ctx;

    // Classification handed from front to back
    typedef struct packed {
        logic       in_map;
        logic       in_field;
        logic [2:0] beam;
        logic [1:0] verdict;
    } t_cls;

    // Shortest angular distance of two binary angles
    function automatic logic [15:0] ang_diff(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d <= HALF_TURN) ? d : (16'd0 - d);
    endfunction

endpackage

// ----- hw/rtl/occupancy_grid_cell_update_top.sv -----
// Top level of the occupancy grid cell updater: registers, front, queue and back.
//
// Takes one cell update per clock, unless held by back-pressure or the clearing sweep,
// and returns one result per cell in order. An item passes offset, square and
// pre-rotation stages, a 15-stage CORDIC for the bearing, then beam choice, range
// squares and the sensor model, a 4-entry queue, and a read-modify-write of the map
// memory (one read and one write a cycle) with forwarding between back-to-back updates
// of one cell. After reset the map is swept to zero, one cell a cycle, over all
// MAP_WIDTH*MAP_HEIGHT cells (4096 by default), and no item is taken until that ends;
// register writes are taken at any time.
module occupancy_grid_cell_update_top
    import ogcu_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [5:0]        i_cell_x,
    input  logic [5:0]        i_cell_y,
    input  logic [15:0]       i_robot_x,
    input  logic [15:0]       i_robot_y,
    input  logic [15:0]       i_heading,
    input  logic [15:0]       i_range_0,
    input  logic [15:0]       i_range_1,
    input  logic [15:0]       i_range_2,
    input  logic [15:0]       i_range_3,
    input  logic [15:0]       i_range_4,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [7:0] o_cell_value,
    output logic              o_in_field,
    output logic [2:0]        o_beam_used,
    output logic [1:0]        o_verdict
);
    localparam int AW = $clog2(MAP_WIDTH * MAP_HEIGHT);

    t_cfg          r_cfg;
    logic          front_en, clearing, q_full, q_empty, push, pop;
    logic [AW-1:0] f_addr, q_addr;
    t_cls          f_cls, q_cls;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = front_en && !clearing;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_reach     <= RST_MAX_REACH;
            r_cfg.field_half    <= RST_FIELD_HALF;
            r_cfg.beam_width    <= RST_BEAM_WIDTH;
            r_cfg.hit_tol       <= RST_HIT_TOL;
            r_cfg.cell_pitch    <= RST_CELL_PITCH;
            r_cfg.center_offset <= RST_CENTER_OFFSET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_REACH:     r_cfg.max_reach     <= i_cfg_data;
                CFG_FIELD_HALF:    r_cfg.field_half    <= i_cfg_data;
                CFG_BEAM_WIDTH:    r_cfg.beam_width    <= i_cfg_data;
                CFG_HIT_TOL:       r_cfg.hit_tol       <= i_cfg_data;
                CFG_CELL_PITCH:    r_cfg.cell_pitch    <= i_cfg_data;
                CFG_CENTER_OFFSET: r_cfg.center_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ogcu_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .AW         (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_take    (i_valid && o_ready),
        .o_en      (front_en),
        .i_cell_x  (i_cell_x),
        .i_cell_y  (i_cell_y),
        .i_robot_x (i_robot_x),
        .i_robot_y (i_robot_y),
        .i_heading (i_heading),
        .i_rng     ({i_range_4, i_range_3, i_range_2, i_range_1, i_range_0}),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_addr    (f_addr),
        .o_cls     (f_cls)
    );

    ogcu_fifo #(
        .WIDTH (AW + $bits(t_cls)),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_addr, f_cls}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  ({q_addr, q_cls})
    );

    ogcu_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .AW         (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_clearing   (clearing),
        .i_q_empty    (q_empty),
        .i_q_addr     (q_addr),
        .i_q_cls      (q_cls),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cell_value (o_cell_value),
        .o_in_field   (o_in_field),
        .o_beam_used  (o_beam_used),
        .o_verdict    (o_verdict)
    );
endmodule

// ----- hw/rtl/ogcu_fifo.sv -----
// Small queue between the classifying front and the map-updating back.
module ogcu_fifo
    import ogcu_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Store beat at write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- hw/rtl/ogcu_front.sv -----
// Front: geometry pipeline that finds distance, bearing, beam and verdict of a cell.
module ogcu_front
    import ogcu_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
    parameter int AW         = $clog2(MAP_WIDTH * MAP_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_take,
    output logic          o_en,
    input  logic [5:0]    i_cell_x,
    input  logic [5:0]    i_cell_y,
    input  logic [15:0]   i_robot_x,
    input  logic [15:0]   i_robot_y,
    input  logic [15:0]   i_heading,
    input  logic [4:0][15:0] i_rng,
    input  logic          i_q_full,
    output logic          o_push,
    output logic [AW-1:0] o_addr,
    output t_cls          o_cls
);
    localparam int NS = CORDIC_STEPS;

    logic en;

    // Stage A: offsets
    logic                 r_a_v;
    logic signed [DW-1:0] r_a_dx, r_a_dy;
    logic [AW-1:0]        r_a_addr;
    t_ctx                 r_a_ctx;

    // Stage B and CORDIC stages share arrays, index 0 is stage B
    logic [NS:0]          r_v;
    logic signed [CW-1:0] r_x   [0:NS];
    logic signed [CW-1:0] r_y   [0:NS];
    logic [15:0]          r_ang [0:NS];
    t_ctx                 r_ctx [0:NS];
    logic [AW-1:0]        r_adr [0:NS];

    // Stage D: field and beam
    logic          r_d_v, r_d_field;
    logic [15:0]   r_d_phi, r_d_th;
    logic [2:0]    r_d_k;
    t_ctx          r_d_ctx;
    logic [AW-1:0] r_d_addr;

    // Stage E: squared ranges
    logic          r_e_v, r_e_field, r_e_wide, r_e_zlt_rm, r_e_zlt_a;
    logic [31:0]   r_e_zmin2, r_e_lo2;
    logic [33:0]   r_e_hi2;
    logic [SW-1:0] r_e_s;
    logic [2:0]    r_e_k;
    logic          r_e_in_map;
    logic [AW-1:0] r_e_addr;

    // Stage F: classified item
    logic          r_f_v;
    t_cls          r_f_cls;
    logic [AW-1:0] r_f_addr;

    assign en     = !r_f_v || !i_q_full;
    assign o_en   = en;
    assign o_push = r_f_v && !i_q_full;
    assign o_addr = r_f_addr;
    assign o_cls  = r_f_cls;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_v   <= '0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_take;
            r_v   <= {r_v[NS-1:0], r_a_v};
            r_d_v <= r_v[NS];
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    // Stage A: cell centre minus robot position
    logic [22:0] cx_c, cy_c;
    logic        in_map;
    always_comb begin
        cx_c   = 23'(i_cell_x) * 23'(i_cfg.cell_pitch) + 23'(i_cfg.center_offset);
        cy_c   = 23'(i_cell_y) * 23'(i_cfg.cell_pitch) + 23'(i_cfg.center_offset);
        in_map = (int'(i_cell_x) < MAP_WIDTH) && (int'(i_cell_y) < MAP_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx <= $signed({1'b0, cx_c}) - $signed({8'b0, i_robot_x});
            r_a_dy <= $signed({1'b0, cy_c}) - $signed({8'b0, i_robot_y});
            r_a_addr <= in_map ? AW'(i_cell_y) * AW'(MAP_WIDTH) + AW'(i_cell_x) : '0;
            r_a_ctx.head   <= i_heading;
            r_a_ctx.rng    <= i_rng;
            r_a_ctx.in_map <= in_map;
            r_a_ctx.zero   <= 1'b0;
            r_a_ctx.sqx    <= '0;
            r_a_ctx.sqy    <= '0;
            r_a_ctx.s      <= '0;
            r_a_ctx.rm2    <= '0;
        end
    end

    // Stage B: squares and CORDIC pre-rotation into the right half plane
    logic signed [2*DW-1:0] px, py;
    logic signed [CW-1:0]   x0, y0;
    t_ctx                   b_ctx;
    always_comb begin
        px = r_a_dx * r_a_dx;
        py = r_a_dy * r_a_dy;
        x0 = CW'(r_a_dx) <<< 8;
        y0 = CW'(r_a_dy) <<< 8;
        b_ctx      = r_a_ctx;
        b_ctx.sqx  = px[QW-1:0];
        b_ctx.sqy  = py[QW-1:0];
        b_ctx.zero = (r_a_dx == '0) && (r_a_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]   <= r_a_dx[DW-1] ? -x0 : x0;
            r_y[0]   <= r_a_dx[DW-1] ? -y0 : y0;
            r_ang[0] <= r_a_dx[DW-1] ? HALF_TURN : 16'd0;
            r_ctx[0] <= b_ctx;
            r_adr[0] <= r_a_addr;
        end
    end

    // CORDIC vectoring: one micro-rotation per stage
    for (genvar k = 0; k < NS; k++) begin : g_cordic
        t_ctx c_next;
        always_comb begin
            c_next = r_ctx[k];
            if (k == 0) begin
                c_next.s   = SW'(r_ctx[k].sqx) + SW'(r_ctx[k].sqy);
                c_next.rm2 = 32'(i_cfg.max_reach) * 32'(i_cfg.max_reach);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_y[k][CW-1]) begin
                    r_x[k+1]   <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1]   <= r_y[k] - (r_x[k] >>> k);
                    r_ang[k+1] <= r_ang[k] + ATAN_TAB[k];
                end else begin
                    r_x[k+1]   <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1]   <= r_y[k] + (r_x[k] >>> k);
                    r_ang[k+1] <= r_ang[k] - ATAN_TAB[k];
                end
                r_ctx[k+1] <= c_next;
                r_adr[k+1] <= r_adr[k];
            end
        end
    end

    // Stage D: field test and closest beam
    logic [15:0] phi, th, dj, best, th_k;
    logic [2:0]  k_sel;
    logic        field;
    always_comb begin
        phi   = r_ctx[NS].zero ? 16'd0 : r_ang[NS];
        field = r_ctx[NS].in_map && (r_ctx[NS].s <= SW'(r_ctx[NS].rm2)) &&
                (ang_diff(r_ctx[NS].head, phi) <= i_cfg.field_half);
        best  = 16'hFFFF;
        k_sel = 3'd0;
        th_k  = 16'd0;
        for (int j = 0; j < 5; j++) begin
            th = r_ctx[NS].head + BEAM_FIRST + 16'(j) * BEAM_STEP;
            dj = (phi >= th) ? phi - th : th - phi;
            if (j == 0 || dj < best) begin
                best  = dj;
                k_sel = 3'(j);
                th_k  = th;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_field <= field;
            r_d_phi   <= phi;
            r_d_th    <= th_k;
            r_d_k     <= k_sel;
            r_d_ctx   <= r_ctx[NS];
            r_d_addr  <= r_adr[NS];
        end
    end

    // Stage E: squares of the chosen range and its tolerance band
    logic [15:0] zk, zmin;
    logic [16:0] zhi;
    logic [15:0] zlo;
    always_comb begin
        zk   = r_d_ctx.rng[r_d_k];
        zmin = (zk < i_cfg.max_reach) ? zk : i_cfg.max_reach;
        zhi  = 17'(zk) + 17'(i_cfg.hit_tol);
        zlo  = zk - i_cfg.hit_tol;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_zmin2  <= 32'(zmin) * 32'(zmin);
            r_e_hi2    <= 34'(zhi) * 34'(zhi);
            r_e_lo2    <= 32'(zlo) * 32'(zlo);
            r_e_zlt_rm <= zk < i_cfg.max_reach;
            r_e_zlt_a  <= zk < i_cfg.hit_tol;
            r_e_wide   <= {ang_diff(r_d_phi, r_d_th), 1'b0} > {1'b0, i_cfg.beam_width};
            r_e_field  <= r_d_field;
            r_e_s      <= r_d_ctx.s;
            r_e_k      <= r_d_k;
            r_e_in_map <= r_d_ctx.in_map;
            r_e_addr   <= r_d_addr;
        end
    end

    // Stage F: inverse sensor model
    logic [1:0] verdict;
    always_comb begin
        if (r_e_s > SW'(r_e_zmin2) || r_e_wide) begin
            verdict = VERDICT_UNKNOWN;
        end else if (r_e_zlt_rm && r_e_s < SW'(r_e_hi2) &&
                     (r_e_zlt_a || r_e_s > SW'(r_e_lo2))) begin
            verdict = VERDICT_OCC;
        end else begin
            verdict = VERDICT_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_cls.in_map   <= r_e_in_map;
            r_f_cls.in_field <= r_e_field;
            r_f_cls.beam     <= r_e_field ? r_e_k : 3'd0;
            r_f_cls.verdict  <= r_e_field ? verdict : VERDICT_UNKNOWN;
            r_f_addr         <= r_e_addr;
        end
    end
endmodule

// ----- hw/rtl/ogcu_back.sv -----
// Back: log-odds map memory, read-modify-write of one cell per beat, result register.
module ogcu_back
    import ogcu_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
    parameter int AW         = $clog2(MAP_WIDTH * MAP_HEIGHT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_clearing,
    input  logic              i_q_empty,
    input  logic [AW-1:0]     i_q_addr,
    input  t_cls              i_q_cls,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [7:0] o_cell_value,
    output logic              o_in_field,
    output logic [2:0]        o_beam_used,
    output logic [1:0]        o_verdict
);
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;

    logic signed [7:0] r_mem [DEPTH];

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic              r_b_v, r_b_hit;
    logic [AW-1:0]     r_b_addr;
    t_cls              r_b_cls;
    logic signed [7:0] r_b_rd, r_b_fwd;

    logic              r_out_v;
    logic signed [7:0] r_out_value;
    logic              r_out_field;
    logic [2:0]        r_out_beam;
    logic [1:0]        r_out_verdict;

    logic              out_free, b_go, b_load, pop, wr_en;
    logic [AW-1:0]     wr_addr;
    logic signed [7:0] old_v, new_v, wr_data;
    logic signed [8:0] sum;

    assign out_free = !r_out_v || i_ready;
    assign b_go     = r_b_v && out_free;
    assign b_load   = !r_b_v || b_go;
    assign pop      = !i_q_empty && b_load && !r_clearing;
    assign o_pop    = pop;
    assign o_clearing = r_clearing;

    // Update the cell value
    always_comb begin
        old_v = r_b_hit ? r_b_fwd : r_b_rd;
        sum   = 9'(old_v);
        if (r_b_cls.verdict == VERDICT_OCC) begin
            sum = sum + L_OCC;
        end else if (r_b_cls.verdict == VERDICT_FREE) begin
            sum = sum + L_FREE;
        end
        if (sum > LO_MAX) begin
            sum = LO_MAX;
        end else if (sum < LO_MIN) begin
            sum = LO_MIN;
        end
        if (!r_b_cls.in_map) begin
            new_v = 8'sd0;
        end else if (!r_b_cls.in_field) begin
            new_v = old_v;
        end else begin
            new_v = sum[7:0];
        end
    end

    // Select write port source: clearing sweep or cell update
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 8'sd0;
        end else begin
            wr_en   = b_go && r_b_cls.in_field;
            wr_addr = r_b_addr;
            wr_data = new_v;
        end
    end

    // Map memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (pop) begin
            r_b_rd <= r_mem[i_q_addr];
        end
    end

    // Sweep the map to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Hold the popped beat, forward a write that lands on its cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_load) begin
            r_b_v <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_addr <= i_q_addr;
            r_b_cls  <= i_q_cls;
            r_b_hit  <= wr_en && (wr_addr == i_q_addr);
            r_b_fwd  <= wr_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (b_go) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_out_value   <= new_v;
            r_out_field   <= r_b_cls.in_field;
            r_out_beam    <= r_b_cls.beam;
            r_out_verdict <= r_b_cls.verdict;
        end
    end

    assign o_valid      = r_out_v;
    assign o_cell_value = r_out_value;
    assign o_in_field   = r_out_field;
    assign o_beam_used  = r_out_beam;
    assign o_verdict    = r_out_verdict;
endmodule
